// ----- rtl/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and codes for the set-associative LRU cache tag store.
// ----------------------------------------------------------------------------
package sac_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_USED  = 2'd2;

    localparam int AGE_W   = 3;
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 32;
    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    // outcome of the first access
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // one result item
    typedef struct packed {
        logic [CNT_W-1:0] eviction_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] hit_count;
        logic             second_hit;
        logic [1:0]       outcome;
    } res_t;

endpackage

// ----- rtl/sac_front.sv -----
// ----------------------------------------------------------------------------
// sac_front
// Holds the geometry registers and splits each address into set and tag.
// ----------------------------------------------------------------------------
module sac_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int SET_IW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [4:0]        cfg_data,
    input  logic [31:0]       address,
    output logic [SET_IW-1:0] set_idx,
    output logic [31:0]       tag,
    output logic [4:0]        nways
);

    logic [2:0] set_bits_reg;
    logic [4:0] block_bits_reg;
    logic [3:0] ways_used_reg;
    logic [3:0] sb;
    logic [5:0] sh;
    logic [31:0] above_block;
    logic [SET_IW-1:0] set_mask;

    // geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            ways_used_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sac_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                sac_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                sac_pkg::CFG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // saturate set bits and ways in use
    always_comb
    begin
        sb = ({1'b0, set_bits_reg} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                         : {1'b0, set_bits_reg};
        if (ways_used_reg == 4'd0)
            nways = 5'd1;
        else if ({1'b0, ways_used_reg} > 5'(WAYS))
            nways = 5'(WAYS);
        else
            nways = {1'b0, ways_used_reg};
    end

    // address split
    always_comb
    begin
        sh          = 6'(block_bits_reg) + 6'(sb);
        above_block = address >> block_bits_reg;
        set_mask    = ~({SET_IW{1'b1}} << sb);
        set_idx     = above_block[SET_IW-1:0] & set_mask;
        tag         = (sh >= 6'd32) ? 32'd0 : (address >> sh[4:0]);
    end

endmodule

// ----- rtl/sac_queue.sv -----
// ----------------------------------------------------------------------------
// sac_queue
// Two-entry queue between the classifying front and the lookup back.
// ----------------------------------------------------------------------------
module sac_queue #(
    parameter int DW = 39
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] pop_data
);

    logic [DW-1:0] slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/sac_back.sv -----
// ----------------------------------------------------------------------------
// sac_back
// Set row memory, hit/victim selection, LRU aging, totals and output register.
// ----------------------------------------------------------------------------
module sac_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int SET_IW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         nways,
    input  logic               q_not_empty,
    input  logic [SET_IW+32:0] q_data,
    output logic               q_pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_ready,
    output sac_pkg::res_t      out_res
);

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int LW    = 1 + sac_pkg::AGE_W + sac_pkg::TAG_W;
    localparam int RW    = WAYS * LW;
    localparam int WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    logic [RW-1:0] row_mem [SETS];
    logic [RW-1:0] rd_row_reg;
    logic [RW-1:0] wr_row;

    state_t state_reg, state_next;
    logic [SET_IW-1:0] clr_cnt_reg;
    logic              req_func_reg;
    logic [SET_IW-1:0] req_set_reg;
    logic [31:0]       req_tag_reg;

    logic [31:0] hits_reg, misses_reg, evicts_reg;
    logic        out_valid_reg;
    sac_pkg::res_t out_res_reg;

    logic                    commit;
    logic [WAYS-1:0]         v, act, match, inv, vic;
    logic [sac_pkg::AGE_W-1:0] age [WAYS];
    logic [31:0]             ltag [WAYS];
    logic                    hit, any_inv;
    logic [WIW-1:0]          hway, fway, vway, sel;
    logic [3:0]              limit;
    logic [1:0]              outcome;

    assign clearing  = (state_reg == ST_CLEAR);
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign commit    = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // unpack the row and classify each way
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            v[w]    = rd_row_reg[w*LW + LW - 1];
            age[w]  = rd_row_reg[w*LW + 32 +: sac_pkg::AGE_W];
            ltag[w] = rd_row_reg[w*LW +: 32];
            act[w]  = (5'(w) < nways);
            match[w] = act[w] && v[w] && (ltag[w] == req_tag_reg);
            inv[w]   = act[w] && !v[w];
        end
    end

    // victim candidates: oldest way, lowest index on ties
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            vic[w] = act[w];
            for (int j = 0; j < WAYS; j++)
            begin
                if (act[j] && j < w && !(age[w] > age[j]))
                    vic[w] = 1'b0;
                if (act[j] && j > w && (age[w] < age[j]))
                    vic[w] = 1'b0;
            end
        end
    end

    // priority picks
    always_comb
    begin
        hway = '0;
        fway = '0;
        vway = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
                hway = WIW'(w);
            if (inv[w])
                fway = WIW'(w);
            if (vic[w])
                vway = WIW'(w);
        end
        hit     = |match;
        any_inv = |inv;
        if (hit)
        begin
            sel     = hway;
            limit   = {1'b0, age[hway]};
            outcome = sac_pkg::OUT_HIT;
        end
        else if (any_inv)
        begin
            sel     = fway;
            limit   = 4'd8;
            outcome = sac_pkg::OUT_MISS;
        end
        else
        begin
            sel     = vway;
            limit   = 4'd8;
            outcome = sac_pkg::OUT_EVICT;
        end
    end

    // updated row with LRU aging
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (WIW'(w) == sel)
                wr_row[w*LW +: LW] = {1'b1, {sac_pkg::AGE_W{1'b0}},
                                      hit ? ltag[w] : req_tag_reg};
            else if (act[w] && v[w] && ({1'b0, age[w]} < limit)
                     && (age[w] != sac_pkg::AGE_MAX))
                wr_row[w*LW +: LW] = {1'b1, age[w] + 3'd1, ltag[w]};
            else
                wr_row[w*LW +: LW] = rd_row_reg[w*LW +: LW];
        end
    end

    // row memory: clearing pass, read on pop, write on commit
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            row_mem[clr_cnt_reg] <= '0;
        else if (commit)
            row_mem[req_set_reg] <= wr_row;
        if (q_pop)
            rd_row_reg <= row_mem[q_data[SET_IW+31:32]];
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_func_reg <= q_data[SET_IW+32];
            req_set_reg  <= q_data[SET_IW+31:32];
            req_tag_reg  <= q_data[31:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == SET_IW'(SETS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_not_empty)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                if (commit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // totals and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                hits_reg   <= hits_reg + 32'(hit) + 32'(req_func_reg);
                misses_reg <= misses_reg + 32'(!hit);
                evicts_reg <= evicts_reg + 32'(!hit && !any_inv);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_res_reg.outcome        <= outcome;
            out_res_reg.second_hit     <= req_func_reg;
            out_res_reg.hit_count      <= hits_reg + 32'(hit) + 32'(req_func_reg);
            out_res_reg.miss_count     <= misses_reg + 32'(!hit);
            out_res_reg.eviction_count <= evicts_reg + 32'(!hit && !any_inv);
        end
    end

    // checks
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("result not presented after commit");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("queue popped during clearing pass");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> hits_reg == $past(hits_reg) + 32'($past(hit))
                   + 32'($past(req_func_reg)))
        else $error("hit total out of step");

endmodule

// ----- rtl/set_assoc_lru_cache_sim.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
//  channel   | signals                         | carries
//  s_axis    | tvalid tready tdata tuser       | address; tuser = func
//  m_axis    | tvalid tready tdata             | outcome, second_hit, totals
//  cfg       | cfg_we cfg_index cfg_data       | set_bits, block_bits, ways_used
//
//  In the lookup unit each item gets a set row read, then compare, age
//  update, row write back and result register load; items go one at a time.
//  After reset a clearing pass over all 2**MAX_SET_BITS sets blocks input.
//  A full result register stalls the lookup unit; the two-entry queue
//  keeps taking input until it is full.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // address[31:0]
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // outcome[1:0], second_hit[2], hit_count[34:3], miss_count[66:35],
    // eviction_count[98:67], zero fill
    output logic [103:0] m_axis_tdata
);

    localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int QW     = SET_IW + 33;

    logic [SET_IW-1:0] set_idx;
    logic [31:0]       tag;
    logic [4:0]        nways;
    logic              q_full, q_not_empty, q_pop, clearing, push;
    logic [QW-1:0]     q_data;
    sac_pkg::res_t     res;

    assign s_axis_tready = !q_full && !clearing;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = {5'd0, res};

    sac_front #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS), .SET_IW(SET_IW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .address   (s_axis_tdata),
        .set_idx   (set_idx),
        .tag       (tag),
        .nways     (nways)
    );

    sac_queue #(.DW(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({s_axis_tuser, set_idx, tag}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    sac_back #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS), .SET_IW(SET_IW)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .nways       (nways),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (res)
    );

endmodule

// ----- tb/sv/set_assoc_lru_cache_sim_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_chk
// Watches the input, config and result channels of the LRU tag store, keeps
// its own tag/age model, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_chk (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    output int           errors,
    output int           pending
);

    localparam int NSETS = 64;
    localparam int NWAYS = 8;

    logic [2:0]  set_bits_q;
    logic [4:0]  block_bits_q;
    logic [3:0]  ways_q;
    logic        vld   [NSETS*NWAYS];
    logic [31:0] tags  [NSETS*NWAYS];
    logic [2:0]  ages  [NSETS*NWAYS];
    logic [31:0] hits, misses, evicts;
    sac_pkg::res_t expected_q[$];

    // move one way to most recent, age the younger valid ways
    function automatic void promote(int base, int nw, int way, int lim);
        for (int w = 0; w < nw; w++)
            if (w != way && vld[base+w] && ages[base+w] < lim
                && ages[base+w] != sac_pkg::AGE_MAX)
                ages[base+w] = ages[base+w] + 3'd1;
        ages[base+way] = '0;
    endfunction

    function automatic logic [1:0] lookup(logic [31:0] addr);
        int sb, nw, base, victim, sh;
        logic [63:0] a;
        logic [31:0] tag;
        sb = (set_bits_q > 6) ? 6 : set_bits_q;
        nw = (ways_q == 0) ? 1 : ((ways_q > NWAYS) ? NWAYS : ways_q);
        a = {32'd0, addr};
        sh = block_bits_q + sb;
        base = int'((a >> block_bits_q) & ((64'd1 << sb) - 1)) * NWAYS;
        tag = (sh >= 32) ? 32'd0 : 32'(a >> sh);
        for (int w = 0; w < nw; w++)
            if (vld[base+w] && tags[base+w] == tag)
            begin
                promote(base, nw, w, ages[base+w]);
                hits++;
                return sac_pkg::OUT_HIT;
            end
        misses++;
        for (int w = 0; w < nw; w++)
            if (!vld[base+w])
            begin
                vld[base+w] = 1'b1;
                tags[base+w] = tag;
                promote(base, nw, w, 8);
                return sac_pkg::OUT_MISS;
            end
        evicts++;
        victim = 0;
        for (int w = 1; w < nw; w++)
            if (ages[base+w] > ages[base+victim])
                victim = w;
        tags[base+victim] = tag;
        promote(base, nw, victim, 8);
        return sac_pkg::OUT_EVICT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sac_pkg::res_t exp_r, got;
        if (!rst_n)
        begin
            set_bits_q <= '0;
            block_bits_q <= '0;
            ways_q <= 4'd1;
            hits = 0; misses = 0; evicts = 0;
            for (int i = 0; i < NSETS*NWAYS; i++)
            begin
                vld[i] = 1'b0; tags[i] = '0; ages[i] = '0;
            end
            expected_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            // config writes
            if (cfg_we)
                case (cfg_index)
                    sac_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
                    sac_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data;
                    sac_pkg::CFG_WAYS_USED:  ways_q       <= cfg_data[3:0];
                    default: ;
                endcase
            // input transfer: predict
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_r = '0;
                exp_r.outcome = lookup(s_axis_tdata);
                if (s_axis_tuser)
                    exp_r.second_hit = (lookup(s_axis_tdata) == sac_pkg::OUT_HIT);
                exp_r.hit_count = hits;
                exp_r.miss_count = misses;
                exp_r.eviction_count = evicts;
                expected_q.push_back(exp_r);
            end
            // result transfer: compare
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = sac_pkg::res_t'(m_axis_tdata[98:0]);
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r || m_axis_tdata[103:99] !== '0)
                    begin
                        $display("%0t: outcome expected %0d actual %0d", $time,
                                 exp_r.outcome, got.outcome);
                        $display("%0t: second_hit expected %0d actual %0d", $time,
                                 exp_r.second_hit, got.second_hit);
                        $display("%0t: hits expected %0d actual %0d", $time,
                                 exp_r.hit_count, got.hit_count);
                        $display("%0t: misses expected %0d actual %0d", $time,
                                 exp_r.miss_count, got.miss_count);
                        $display("%0t: evictions expected %0d actual %0d", $time,
                                 exp_r.eviction_count, got.eviction_count);
                        errors <= errors + 1;
                    end
                end
            end
            // items still owed a result
            pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/set_assoc_lru_cache_sim_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_tb
// Drives directed and random address streams through the LRU tag store over
// several cache geometries, with random gaps, stalls and one long stall.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_tb;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [4:0]   cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    int           errors;
    int           pending;
    int           cycles = 0;
    int           sent = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;
    logic [31:0]  tag_pool[8];

    always #2 clk = ~clk;

    set_assoc_lru_cache_sim DUT (.*);

    set_assoc_lru_cache_sim_chk u_chk (.*);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("set_assoc_lru_cache_sim_tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_req = 1'b0;
            end
            if (!calm && $urandom_range(3) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(7, 1);
                repeat (n - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [4:0] sb, logic [4:0] bb, logic [4:0] wu);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        write_reg(sac_pkg::CFG_SET_BITS, sb);
        write_reg(sac_pkg::CFG_BLOCK_BITS, bb);
        write_reg(sac_pkg::CFG_WAYS_USED, wu);
    endtask

    // one input transfer, optional random gap first
    task automatic send_access(logic func, logic [31:0] addr);
        int n;
        if (!calm && $urandom_range(4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(7, 1);
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= addr;
        s_axis_tuser <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // addresses biased to a few tags so hits and evictions both happen
    task automatic random_phase(int count, int bb, int sb);
        logic [31:0] addr;
        int sh;
        sh = bb + sb;
        for (int i = 0; i < 8; i++)
            tag_pool[i] = $urandom;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8 && sh < 32)
                addr = (tag_pool[$urandom_range(7)] << sh)
                     | ($urandom & ((32'd1 << sh) - 1));
            else
                addr = $urandom;
            send_access(1'($urandom_range(1)), addr);
        end
        end_burst();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default geometry, field extremes, both kinds
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b0, 32'h0000_0000);
        end_burst();

        // out of range values: set bits saturate, ways 0 acts as 1, huge block
        set_geometry(5'd7, 5'd31, 5'd0);
        send_access(1'b0, 32'h1234_5678);
        send_access(1'b1, 32'h8765_4321);
        end_burst();
        set_geometry(5'd2, 5'd4, 5'd15);
        for (int i = 0; i < 10; i++)
            send_access(i[0], {i[3:0], 28'h0} | 32'h30);
        send_access(1'b0, 32'h0000_0030);
        end_burst();

        // shrinking ways keeps contents, upper ways ignored
        set_geometry(5'd2, 5'd4, 5'd3);
        send_access(1'b0, 32'h1000_0030);
        send_access(1'b0, 32'h7000_0030);
        end_burst();

        // random phases over several geometries
        set_geometry(5'd0, 5'd0, 5'd1);
        random_phase(150, 0, 0);
        set_geometry(5'd6, 5'd26, 5'd8);
        random_phase(150, 26, 6);
        set_geometry(5'd3, 5'd5, 5'd4);
        random_phase(250, 5, 3);
        set_geometry(5'd1, 5'd2, 5'd2);
        random_phase(200, 2, 1);

        // long receiver stall while input keeps coming
        set_geometry(5'd4, 5'd6, 5'd8);
        hold_req = 1'b1;
        random_phase(300, 6, 4);
        set_geometry(5'd6, 5'd0, 5'd7);
        random_phase(300, 0, 6);
        set_geometry(5'd2, 5'd3, 5'd8);
        calm = 1'b1;
        random_phase(280, 3, 2);

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("set_assoc_lru_cache_sim_tb OK");
        else
            $display("set_assoc_lru_cache_sim_tb NOT OK");
        $finish;
    end

endmodule
